// File: hw/rtl/gtpd_pkg.sv
package gtpd_pkg;

	// stream payload widths
	localparam int IN_TDATA_W  = 128;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 3;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STILL_ACCEL_TOL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_GYRO_RATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_SHIFT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_DEGREE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_AXES       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_US       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_US      = 3'd7;

	// register values after reset
	localparam logic [12:0] RST_STILL_ACCEL_TOL   = 13'd410;
	localparam logic [14:0] RST_STILL_GYRO_RATE   = 15'd192;
	localparam logic [3:0]  RST_BIAS_SHIFT        = 4'd8;
	localparam logic [31:0] RST_DEAD_ZONE         = 32'd1280000;
	localparam logic [7:0]  RST_PIXELS_PER_DEGREE = 8'd50;
	localparam logic [1:0]  RST_INVERT_AXES       = 2'd0;
	localparam logic [19:0] RST_MAX_STEP_US       = 20'd100000;
	localparam logic [19:0] RST_HOLD_TIME_US      = 20'd200000;

	// arithmetic constants
	localparam int ONE_G         = 4096;
	localparam int UNKNOWN_DT_US = 5000;
	localparam int FRAC_BITS     = 26;
	localparam int PIX_DIV       = 62500;
	localparam int DELTA_MAX     = 127;

endpackage

// File: hw/rtl/gyro_to_pointer_delta_core.sv
// Gyro to pointer delta core. Each request on the s_ stream carries one IMU sample (three
// gyro rates in 1/64 dps, three accel axes in 1/4096 g, elapsed microseconds) plus click and
// link flags, and produces exactly one request on the m_ stream with the pixel deltas and
// three status flags. Stillness is judged from squared accel and gyro norms; while still, the
// pitch and yaw biases creep toward the raw rates. Bias-corrected rates times the step time
// (zero time counts as 5 ms, long gaps clamp to max_step_us) give angles; above the dead zone
// they are scaled to pixels with a sub-pixel residual, below it the residuals decay by half.
// A click opens a hold window that masks report_valid. Flow: the block takes one sample at
// a time and s_tready is low while it works. When both axes stay inside the dead zone, a
// sample runs only the multiply steps on the one shared 34x29 multiplier (norms, thresholds,
// angles, scaled angles); otherwise these are followed, per axis, by one load, 15 radix-16
// steps of the divide by 62500 and an emit step; last, the result is handed to the
// output register. The output register frees the input side: a new sample is taken while the
// previous result still waits for m_tready, and further wait on m_tready adds cycles only when
// a finished result finds that register still full. Configuration writes are always taken
// (cfg_ready is tied high) and must only be issued while the block is idle.
module gyro_to_pointer_delta_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// rate_roll, rate_pitch, rate_yaw, accel_x, accel_y, accel_z, elapsed_us
	input  logic [gtpd_pkg::IN_TDATA_W-1:0]    s_tdata,
	// click_seen, link_up
	input  logic [gtpd_pkg::IN_TUSER_W-1:0]    s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// delta_x, delta_y
	output logic [gtpd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// report_valid, is_still, above_dead_zone
	output logic [gtpd_pkg::OUT_TUSER_W-1:0]   m_tuser,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gtpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gtpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import gtpd_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DLOAD = 3'd2;
	localparam logic [2:0] ST_DRUN  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	// last multiply step and last divider step
	localparam logic [3:0] MUL_LAST = 4'd14;
	localparam logic [3:0] DIV_LAST = 4'd14;

	// control state
	logic [2:0] state_q;
	logic [3:0] step_q;
	logic [3:0] cnt_q;
	logic       axis_q;     // 0 vertical (pitch), 1 horizontal (yaw)
	logic       m_tvalid_q;

	// configuration registers
	logic [12:0] still_accel_tol_q;
	logic [14:0] still_gyro_rate_q;
	logic [3:0]  bias_shift_q;
	logic [31:0] dead_zone_q;
	logic [7:0]  pixels_per_degree_q;
	logic [1:0]  invert_axes_q;
	logic [19:0] max_step_us_q;
	logic [19:0] hold_time_us_q;

	// tracking state across samples
	logic signed [31:0] bias_pitch_q;
	logic signed [31:0] bias_yaw_q;
	logic signed [27:0] res_horiz_q;
	logic signed [27:0] res_vert_q;
	logic        [19:0] hold_left_q;

	// captured sample
	logic signed [15:0] rate_roll_q;
	logic signed [15:0] rate_pitch_q;
	logic signed [15:0] rate_yaw_q;
	logic signed [15:0] accel_x_q;
	logic signed [15:0] accel_y_q;
	logic signed [15:0] accel_z_q;
	logic        [31:0] elapsed_q;
	logic               click_q;
	logic               link_q;
	logic        [19:0] dt_q;

	// work registers
	logic signed [62:0] prod_q;
	logic        [33:0] acc_q;
	logic               hi_ok_q;
	logic               acc_ok_q;
	logic               still_q;
	logic        [27:0] dtppd_q;
	logic signed [52:0] ang_p_q;
	logic signed [52:0] ang_y_q;
	logic               trig_p_q;
	logic               trig_q;
	logic signed [60:0] num_p_q;
	logic signed [60:0] num_y_q;
	logic        [59:0] div_q;
	logic        [15:0] rem_q;
	logic               neg_q;
	logic signed [7:0]  dx_q;
	logic signed [7:0]  dy_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;

	// handshakes
	logic in_req;
	logic out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_req    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// step time: unknown becomes 5 ms, then clamp to max_step_us
	logic [31:0] el_in;
	logic [31:0] el_sub;
	logic [19:0] dt_in;

	always_comb begin
		el_in  = s_tdata[127:96];
		el_sub = (el_in == 32'd0) ? 32'(UNKNOWN_DT_US) : el_in;
		dt_in  = (el_sub > {12'd0, max_step_us_q}) ? max_step_us_q : el_sub[19:0];
	end

	// stillness thresholds
	logic        [13:0] acc_hi;
	logic signed [13:0] acc_lo;

	assign acc_hi = 14'(ONE_G) + {1'b0, still_accel_tol_q};
	assign acc_lo = $signed(14'(ONE_G)) - $signed({1'b0, still_accel_tol_q});

	// bias-corrected rates in Q16
	logic signed [33:0] diff_p;
	logic signed [33:0] diff_y;

	assign diff_p = $signed({{2{rate_pitch_q[15]}}, rate_pitch_q, 16'd0})
		- $signed({{2{bias_pitch_q[31]}}, bias_pitch_q});
	assign diff_y = $signed({{2{rate_yaw_q[15]}}, rate_yaw_q, 16'd0})
		- $signed({{2{bias_yaw_q[31]}}, bias_yaw_q});

	// shared bias follower: pitch on step 9, yaw on step 10
	logic signed [33:0] follow_in;
	logic signed [33:0] follow_step;

	always_comb begin
		follow_in   = (step_q == 4'd9) ? diff_p : diff_y;
		follow_step = follow_in >>> bias_shift_q;
	end

	// shared multiplier, operands picked by step
	logic signed [33:0] mul_a;
	logic signed [28:0] mul_b;
	logic signed [62:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			4'd0: begin
				mul_a = {{18{accel_x_q[15]}}, accel_x_q};
				mul_b = {{13{accel_x_q[15]}}, accel_x_q};
			end
			4'd1: begin
				mul_a = {{18{accel_y_q[15]}}, accel_y_q};
				mul_b = {{13{accel_y_q[15]}}, accel_y_q};
			end
			4'd2: begin
				mul_a = {{18{accel_z_q[15]}}, accel_z_q};
				mul_b = {{13{accel_z_q[15]}}, accel_z_q};
			end
			4'd3: begin
				mul_a = {20'd0, acc_hi};
				mul_b = {15'd0, acc_hi};
			end
			4'd4: begin
				mul_a = {{20{acc_lo[13]}}, acc_lo};
				mul_b = {{15{acc_lo[13]}}, acc_lo};
			end
			4'd5: begin
				mul_a = {{18{rate_roll_q[15]}}, rate_roll_q};
				mul_b = {{13{rate_roll_q[15]}}, rate_roll_q};
			end
			4'd6: begin
				mul_a = {{18{rate_pitch_q[15]}}, rate_pitch_q};
				mul_b = {{13{rate_pitch_q[15]}}, rate_pitch_q};
			end
			4'd7: begin
				mul_a = {{18{rate_yaw_q[15]}}, rate_yaw_q};
				mul_b = {{13{rate_yaw_q[15]}}, rate_yaw_q};
			end
			4'd8: begin
				mul_a = {19'd0, still_gyro_rate_q};
				mul_b = {14'd0, still_gyro_rate_q};
			end
			4'd9: begin
				mul_a = {14'd0, dt_q};
				mul_b = {21'd0, pixels_per_degree_q};
			end
			4'd10: begin
				mul_a = diff_p;
				mul_b = {9'd0, dt_q};
			end
			4'd11: begin
				mul_a = diff_y;
				mul_b = {9'd0, dt_q};
			end
			4'd12: begin
				mul_a = diff_p;
				mul_b = {1'b0, dtppd_q};
			end
			4'd13: begin
				mul_a = diff_y;
				mul_b = {1'b0, dtppd_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// stillness decision once the gyro norm and its threshold are in
	logic still_now;

	assign still_now = acc_ok_q && (acc_q < prod_q[33:0]);

	// dead zone test, pitch angle on step 12, yaw angle on step 13
	logic signed [52:0] ang_sel;
	logic        [52:0] ang_mag;
	logic               ang_hit;

	always_comb begin
		ang_sel = (step_q == 4'd12) ? ang_p_q : ang_y_q;
		ang_mag = ang_sel[52] ? 53'(-ang_sel) : 53'(ang_sel);
		ang_hit = ang_mag >= {5'd0, dead_zone_q, 16'd0};
	end

	// divider load: magnitude of scaled angle, final sign with inversion
	logic signed [60:0] num_sel;
	logic        [60:0] num_mag;
	logic               inv_sel;

	always_comb begin
		num_sel = axis_q ? num_y_q : num_p_q;
		num_mag = num_sel[60] ? 61'(-num_sel) : 61'(num_sel);
		inv_sel = axis_q ? invert_axes_q[0] : invert_axes_q[1];
	end

	// radix-16 restoring divide by 62500
	logic [15:0] rem_nx;
	logic [3:0]  qdig;
	logic [16:0] trial;

	always_comb begin
		rem_nx = rem_q;
		qdig   = '0;
		trial  = '0;
		for (int j = 0; j < 4; j++) begin
			trial = {rem_nx, div_q[59-j]};
			if (trial >= 17'(PIX_DIV)) begin
				rem_nx     = 16'(trial - 17'(PIX_DIV));
				qdig[3-j]  = 1'b1;
			end else begin
				rem_nx = trial[15:0];
			end
		end
	end

	// emit: add to residual, split whole pixels, clamp
	logic signed [27:0] res_sel;
	logic signed [46:0] pix_f;
	logic signed [46:0] pix_s;
	logic        [46:0] pix_mag;
	logic        [20:0] whole;
	logic        [6:0]  whole_c;
	logic signed [7:0]  delta_e;
	logic        [27:0] frac;
	logic signed [27:0] res_new;

	always_comb begin
		res_sel = axis_q ? res_horiz_q : res_vert_q;
		pix_f   = neg_q ? -$signed({2'd0, div_q[44:0]}) : $signed({2'd0, div_q[44:0]});
		pix_s   = $signed({{19{res_sel[27]}}, res_sel}) + pix_f;
		pix_mag = pix_s[46] ? 47'(-pix_s) : 47'(pix_s);
		whole   = pix_mag[46:FRAC_BITS];
		whole_c = (whole > 21'(DELTA_MAX)) ? 7'(DELTA_MAX) : whole[6:0];
		delta_e = pix_s[46] ? -$signed({1'b0, whole_c}) : $signed({1'b0, whole_c});
		frac    = {2'd0, pix_mag[FRAC_BITS-1:0]};
		res_new = pix_s[46] ? -$signed(frac) : $signed(frac);
	end

	// residual decay toward zero
	logic signed [27:0] dec_h_sum;
	logic signed [27:0] dec_v_sum;
	logic signed [27:0] dec_h;
	logic signed [27:0] dec_v;

	always_comb begin
		dec_h_sum = res_horiz_q + $signed({27'd0, res_horiz_q[27]});
		dec_v_sum = res_vert_q + $signed({27'd0, res_vert_q[27]});
		dec_h     = dec_h_sum >>> 1;
		dec_v     = dec_v_sum >>> 1;
	end

	// hold window countdown and report decision
	logic [19:0] hold_after;
	logic        report_ok;

	always_comb begin
		hold_after = ({12'd0, hold_left_q} > elapsed_q) ? (hold_left_q - elapsed_q[19:0]) : 20'd0;
		report_ok  = link_q && ((dx_q != 8'sd0) || (dy_q != 8'sd0)) && (hold_after == 20'd0);
	end

	// control, configuration and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			step_q              <= '0;
			cnt_q               <= '0;
			axis_q              <= 1'b0;
			m_tvalid_q          <= 1'b0;
			still_accel_tol_q   <= RST_STILL_ACCEL_TOL;
			still_gyro_rate_q   <= RST_STILL_GYRO_RATE;
			bias_shift_q        <= RST_BIAS_SHIFT;
			dead_zone_q         <= RST_DEAD_ZONE;
			pixels_per_degree_q <= RST_PIXELS_PER_DEGREE;
			invert_axes_q       <= RST_INVERT_AXES;
			max_step_us_q       <= RST_MAX_STEP_US;
			hold_time_us_q      <= RST_HOLD_TIME_US;
			bias_pitch_q        <= '0;
			bias_yaw_q          <= '0;
			res_horiz_q         <= '0;
			res_vert_q          <= '0;
			hold_left_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_STILL_ACCEL_TOL:   still_accel_tol_q   <= cfg_data[12:0];
					REG_STILL_GYRO_RATE:   still_gyro_rate_q   <= cfg_data[14:0];
					REG_BIAS_SHIFT:        bias_shift_q        <= cfg_data[3:0];
					REG_DEAD_ZONE:         dead_zone_q         <= cfg_data[31:0];
					REG_PIXELS_PER_DEGREE: pixels_per_degree_q <= cfg_data[7:0];
					REG_INVERT_AXES:       invert_axes_q       <= cfg_data[1:0];
					REG_MAX_STEP_US:       max_step_us_q       <= cfg_data[19:0];
					REG_HOLD_TIME_US:      hold_time_us_q      <= cfg_data[19:0];
					default: ;
				endcase
			end

			// output register: loads on a finished sample, clears when taken
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					// bias follow needs the stillness verdict first
					if (step_q == 4'd9 && still_now) begin
						bias_pitch_q <= bias_pitch_q + follow_step[31:0];
					end
					if (step_q == 4'd10 && still_q) begin
						bias_yaw_q <= bias_yaw_q + follow_step[31:0];
					end
					if (step_q == MUL_LAST) begin
						if (trig_q) begin
							state_q <= ST_DLOAD;
							axis_q  <= 1'b0;
						end else begin
							res_horiz_q <= dec_h;
							res_vert_q  <= dec_v;
							state_q     <= ST_DONE;
						end
					end
				end
				ST_DLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DRUN;
				end
				ST_DRUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (axis_q) begin
						res_horiz_q <= res_new;
						state_q     <= ST_DONE;
					end else begin
						res_vert_q <= res_new;
						axis_q     <= 1'b1;
						state_q    <= ST_DLOAD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						hold_left_q <= click_q ? hold_time_us_q : hold_after;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_req) begin
			rate_roll_q  <= $signed(s_tdata[15:0]);
			rate_pitch_q <= $signed(s_tdata[31:16]);
			rate_yaw_q   <= $signed(s_tdata[47:32]);
			accel_x_q    <= $signed(s_tdata[63:48]);
			accel_y_q    <= $signed(s_tdata[79:64]);
			accel_z_q    <= $signed(s_tdata[95:80]);
			elapsed_q    <= el_in;
			click_q      <= s_tuser[0];
			link_q       <= s_tuser[1];
			dt_q         <= dt_in;
			dx_q         <= '0;
			dy_q         <= '0;
		end

		if (state_q == ST_MUL) begin
			prod_q <= mul_p;
			// prod_q holds the product issued on the previous step
			case (step_q)
				4'd1: acc_q <= prod_q[33:0];
				4'd2: acc_q <= acc_q + prod_q[33:0];
				4'd3: acc_q <= acc_q + prod_q[33:0];
				4'd4: hi_ok_q <= acc_q < prod_q[33:0];
				4'd5: acc_ok_q <= hi_ok_q && (acc_lo[13] || (acc_q > prod_q[33:0]));
				4'd6: acc_q <= prod_q[33:0];
				4'd7: acc_q <= acc_q + prod_q[33:0];
				4'd8: acc_q <= acc_q + prod_q[33:0];
				4'd9: still_q <= still_now;
				4'd10: dtppd_q <= prod_q[27:0];
				4'd11: ang_p_q <= prod_q[52:0];
				4'd12: begin
					ang_y_q  <= prod_q[52:0];
					trig_p_q <= ang_hit;
				end
				4'd13: begin
					num_p_q <= prod_q[60:0];
					trig_q  <= trig_p_q || ang_hit;
				end
				4'd14: num_y_q <= prod_q[60:0];
				default: ;
			endcase
		end

		if (state_q == ST_DLOAD) begin
			div_q <= num_mag[59:0];
			rem_q <= '0;
			neg_q <= num_sel[60] ^ inv_sel;
		end

		if (state_q == ST_DRUN) begin
			div_q <= {div_q[55:0], qdig};
			rem_q <= rem_nx;
		end

		if (state_q == ST_EMIT) begin
			if (axis_q) begin
				dx_q <= delta_e;
			end else begin
				dy_q <= delta_e;
			end
		end

		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {dy_q, dx_q};
			m_tuser_q <= {trig_q, still_q, report_ok};
		end
	end

endmodule
